### hdl/gnms_pkg.sv
// ----------------------------------------------------------------------------
// gnms_pkg: shared types and constants for gradient non-maximum suppression
// Direction classes, command codes, register indexes and the angle classifier.
// ----------------------------------------------------------------------------
package gnms_pkg;

  localparam int unsigned FW_BITS    = 11;
  localparam int unsigned FH_BITS    = 13;
  localparam int unsigned ANG_BITS   = 16;
  localparam int unsigned ROW_BITS   = 13;
  localparam int unsigned CROW_BITS  = 12;
  localparam int unsigned MIN_SIZE   = 2;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned RST_WIDTH  = 640;
  localparam int unsigned RST_HEIGHT = 480;

  // Class bounds on |angle| in Q2.13: floor(k * 1024 * pi) for k = 1, 3, 5, 7.
  localparam logic [ANG_BITS:0] TH1 = 17'd3216;
  localparam logic [ANG_BITS:0] TH3 = 17'd9650;
  localparam logic [ANG_BITS:0] TH5 = 17'd16084;
  localparam logic [ANG_BITS:0] TH7 = 17'd22518;

  typedef enum logic [1:0] {
    DIR_VERT = 2'd0,  // top and bottom neighbours
    DIR_TLBR = 2'd1,  // top-left and bottom-right
    DIR_HORZ = 2'd2,  // left and right
    DIR_TRBL = 2'd3   // top-right and bottom-left
  } dir_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  // Which neighbours of the centre lie inside the frame, and whether the
  // centre is the last pixel of the frame.
  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
    logic last;
  } nbr_t;

  function automatic dir_e classify(logic signed [ANG_BITS-1:0] a);
    logic signed [ANG_BITS:0] ax;
    logic [ANG_BITS:0]        v;
    dir_e                     d;
    ax = {a[ANG_BITS-1], a};
    v  = ax[ANG_BITS] ? unsigned'(-ax) : unsigned'(ax);
    if (v <= TH1 || v > TH7) begin
      d = DIR_VERT;
    end else if (v <= TH3) begin
      d = DIR_TLBR;
    end else if (v <= TH5) begin
      d = DIR_HORZ;
    end else begin
      d = DIR_TRBL;
    end
    // A negative angle is taken plus pi, which mirrors the two diagonals.
    if (a[ANG_BITS-1] && d == DIR_TLBR) begin
      d = DIR_TRBL;
    end else if (a[ANG_BITS-1] && d == DIR_TRBL) begin
      d = DIR_TLBR;
    end
    return d;
  endfunction

endpackage

### hdl/gnms_ram.sv
// ----------------------------------------------------------------------------
// gnms_ram: generic single-clock RAM
// One write port and one read port; read data is registered (read-first).
// ----------------------------------------------------------------------------
module gnms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/gradient_non_maximum_suppression.sv
// ----------------------------------------------------------------------------
// gradient_non_maximum_suppression: streaming Canny non-maximum suppression
// Thins a raster-order gradient stream to local maxima along the direction.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid_i / in_stall_o): one transaction per pixel in
//   raster order, command_i = pixel. After the last pixel of a frame, send
//   frame_width + 1 flush transactions to drain the remaining results.
// - Output channel (out_valid_o / out_stall_i): one result per centre pixel,
//   in raster order; frame_end_o marks the last pixel of the frame.
// - The frame size is taken from the registers at the first pixel of a
//   frame; writes take effect at the next frame. Sizes saturate into range.
// - Throughput is one transaction per cycle unless stalled, set by the
//   single line-buffer RAM's one write and one prefetch read per cycle.
// - The result for centre c belongs to the transaction that brings pixel
//   c + width + 1 (or the matching flush); it passes through the window
//   stage and then the output register before it shows on the output.
// - While the receiver stalls, one finished result waits in the output
//   register and one more in the window stage; then in_stall_o rises.
// - Reset clears the counters and handshake state at once; the line buffer
//   needs no clearing pass, since no entry is used before it is written.
// ----------------------------------------------------------------------------
module gradient_non_maximum_suppression #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAG_BITS  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_index_i,
  input  logic [gnms_pkg::FH_BITS-1:0]          cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  command_i,
  input  logic [MAG_BITS-1:0]                   magnitude_i,
  input  logic signed [gnms_pkg::ANG_BITS-1:0]  angle_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [MAG_BITS-1:0]                   kept_magnitude_o,
  output logic                                  frame_end_o
);

  localparam int unsigned ColBits  = $clog2(MAX_WIDTH);
  localparam int unsigned WBits    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WordBits = 2 * MAG_BITS + 2;
  localparam int unsigned RstW     = (gnms_pkg::RST_WIDTH > MAX_WIDTH) ?
                                     MAX_WIDTH : gnms_pkg::RST_WIDTH;
  localparam int unsigned RowBits  = gnms_pkg::ROW_BITS;
  localparam int unsigned CRowBits = gnms_pkg::CROW_BITS;

  // Configuration registers and the size latched for the running frame.
  logic [gnms_pkg::FW_BITS-1:0] frame_width_q;
  logic [gnms_pkg::FH_BITS-1:0] frame_height_q;
  logic [WBits-1:0]             cur_w_q, cur_w_d, sat_w;
  logic [RowBits-1:0]           cur_h_q, cur_h_d, sat_h;

  // Input position (virtual during the flush) and centre position.
  logic [ColBits-1:0]  col_q, col_d;
  logic [RowBits-1:0]  row_q, row_d;
  logic [ColBits-1:0]  ccol_q, ccol_d;
  logic [CRowBits-1:0] crow_q, crow_d;

  logic in_accept, is_pixel, draining, active, frame_start, emit, frame_done;
  logic col_wrap, ccol_wrap, crow_last;
  gnms_pkg::nbr_t nbr_d, nbr_q;

  // Line buffer word: {magnitude one row up, magnitude two rows up, class}.
  logic [WordBits-1:0]  ram_wdata, ram_rdata;
  logic [MAG_BITS-1:0]  rd_mag1, rd_mag2;
  gnms_pkg::dir_e       rd_cls, in_cls;

  // 3x3 window, index 2 is the newest column.
  logic [MAG_BITS-1:0] win_top_q [3];
  logic [MAG_BITS-1:0] win_mid_q [3];
  logic [MAG_BITS-1:0] win_bot_q [3];
  gnms_pkg::dir_e      cls_pend_q, cls_ctr_q;

  logic s1_valid_q, s1_valid_d, s1_move, out_can_load;
  logic out_valid_q, out_valid_d;
  logic [MAG_BITS-1:0] out_mag_q;
  logic                out_end_q;

  logic [MAG_BITS-1:0] centre, nbr_a, nbr_b;
  logic                ok_a, ok_b, drop;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= gnms_pkg::FW_BITS'(gnms_pkg::RST_WIDTH);
      frame_height_q <= gnms_pkg::FH_BITS'(gnms_pkg::RST_HEIGHT);
    end else if (cfg_we_i) begin
      case (gnms_pkg::reg_idx_e'(cfg_index_i))
        gnms_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[gnms_pkg::FW_BITS-1:0];
        gnms_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(frame_width_q) < gnms_pkg::MIN_SIZE) begin
      sat_w = WBits'(gnms_pkg::MIN_SIZE);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      sat_w = WBits'(MAX_WIDTH);
    end else begin
      sat_w = WBits'(frame_width_q);
    end
    if (32'(frame_height_q) < gnms_pkg::MIN_SIZE) begin
      sat_h = RowBits'(gnms_pkg::MIN_SIZE);
    end else if (32'(frame_height_q) > gnms_pkg::MAX_HEIGHT) begin
      sat_h = RowBits'(gnms_pkg::MAX_HEIGHT);
    end else begin
      sat_h = RowBits'(frame_height_q);
    end
  end

  // --------------------------------------------------------------- control
  assign out_can_load = !out_valid_q || !out_stall_i;
  assign s1_move      = s1_valid_q && out_can_load;
  assign in_stall_o   = s1_valid_q && !out_can_load;
  assign in_accept    = in_valid_i && !in_stall_o;
  assign is_pixel     = gnms_pkg::cmd_e'(command_i) == gnms_pkg::CMD_PIXEL;
  assign draining     = row_q == cur_h_q;
  // Pixels after the frame is complete and flushes before it are dropped.
  assign active       = in_accept && (is_pixel ? !draining : draining);
  assign frame_start  = in_accept && is_pixel && row_q == '0 && col_q == '0 &&
                        crow_q == '0 && ccol_q == '0;
  assign emit         = active && (!is_pixel || row_q > RowBits'(1) ||
                        (row_q == RowBits'(1) && col_q != '0));

  assign col_wrap  = (WBits'(col_q) + WBits'(1)) == cur_w_q;
  assign ccol_wrap = (WBits'(ccol_q) + WBits'(1)) == cur_w_q;
  assign crow_last = (RowBits'(crow_q) + RowBits'(1)) == cur_h_q;

  always_comb begin
    nbr_d.top   = crow_q != '0;
    nbr_d.bot   = (RowBits'(crow_q) + RowBits'(1)) < cur_h_q;
    nbr_d.left  = ccol_q != '0;
    nbr_d.right = !ccol_wrap;
    nbr_d.last  = ccol_wrap && crow_last;
  end

  assign frame_done = emit && nbr_d.last;

  always_comb begin
    cur_w_d = cur_w_q;
    cur_h_d = cur_h_q;
    col_d   = col_q;
    row_d   = row_q;
    ccol_d  = ccol_q;
    crow_d  = crow_q;
    if (frame_start) begin
      cur_w_d = sat_w;
      cur_h_d = sat_h;
    end
    if (active) begin
      col_d = col_wrap ? '0 : col_q + ColBits'(1);
      if (is_pixel && col_wrap) begin
        row_d = row_q + RowBits'(1);
      end
    end
    if (emit) begin
      ccol_d = ccol_wrap ? '0 : ccol_q + ColBits'(1);
      if (ccol_wrap) begin
        crow_d = crow_q + CRowBits'(1);
      end
    end
    if (frame_done) begin
      col_d  = '0;
      row_d  = '0;
      ccol_d = '0;
      crow_d = '0;
    end
  end

  always_comb begin
    if (active) begin
      s1_valid_d = emit;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    out_valid_d = out_can_load ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_w_q     <= WBits'(RstW);
      cur_h_q     <= RowBits'(gnms_pkg::RST_HEIGHT);
      col_q       <= '0;
      row_q       <= '0;
      ccol_q      <= '0;
      crow_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_w_q     <= cur_w_d;
      cur_h_q     <= cur_h_d;
      col_q       <= col_d;
      row_q       <= row_d;
      ccol_q      <= ccol_d;
      crow_q      <= crow_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ----------------------------------------------------------- line buffer
  // The read address follows the next column, so the word for the next
  // transaction is already registered when it arrives.
  assign in_cls    = gnms_pkg::classify(angle_i);
  assign rd_mag1   = ram_rdata[WordBits-1 -: MAG_BITS];
  assign rd_mag2   = ram_rdata[2 +: MAG_BITS];
  assign rd_cls    = gnms_pkg::dir_e'(ram_rdata[1:0]);
  assign ram_wdata = {magnitude_i, rd_mag1, in_cls};

  gnms_ram #(
    .WIDTH(WordBits),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (active),
    .waddr_i(col_q),
    .wdata_i(ram_wdata),
    .raddr_i(col_d),
    .rdata_o(ram_rdata)
  );

  // ---------------------------------------------------------------- window
  always_ff @(posedge clk_i) begin
    if (active) begin
      win_top_q[0] <= win_top_q[1];
      win_top_q[1] <= win_top_q[2];
      win_top_q[2] <= rd_mag2;
      win_mid_q[0] <= win_mid_q[1];
      win_mid_q[1] <= win_mid_q[2];
      win_mid_q[2] <= rd_mag1;
      win_bot_q[0] <= win_bot_q[1];
      win_bot_q[1] <= win_bot_q[2];
      win_bot_q[2] <= magnitude_i;
      // The centre sits one column behind the newest middle-row entry.
      cls_pend_q   <= rd_cls;
      cls_ctr_q    <= cls_pend_q;
      nbr_q        <= nbr_d;
    end
  end

  // ------------------------------------------------------------ comparison
  assign centre = win_mid_q[1];

  always_comb begin
    case (cls_ctr_q)
      gnms_pkg::DIR_VERT: begin
        nbr_a = win_top_q[1];
        nbr_b = win_bot_q[1];
        ok_a  = nbr_q.top;
        ok_b  = nbr_q.bot;
      end
      gnms_pkg::DIR_TLBR: begin
        nbr_a = win_top_q[0];
        nbr_b = win_bot_q[2];
        ok_a  = nbr_q.top && nbr_q.left;
        ok_b  = nbr_q.bot && nbr_q.right;
      end
      gnms_pkg::DIR_HORZ: begin
        nbr_a = win_mid_q[0];
        nbr_b = win_mid_q[2];
        ok_a  = nbr_q.left;
        ok_b  = nbr_q.right;
      end
      gnms_pkg::DIR_TRBL: begin
        nbr_a = win_top_q[2];
        nbr_b = win_bot_q[0];
        ok_a  = nbr_q.top && nbr_q.right;
        ok_b  = nbr_q.bot && nbr_q.left;
      end
      default: begin
        nbr_a = '0;
        nbr_b = '0;
        ok_a  = 1'b0;
        ok_b  = 1'b0;
      end
    endcase
    drop = (ok_a && centre < nbr_a) || (ok_b && centre < nbr_b);
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_mag_q <= drop ? '0 : centre;
      out_end_q <= nbr_q.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kept_magnitude_o = out_mag_q;
  assign frame_end_o      = out_end_q;

  // ------------------------------------------------------------ assertions
  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WBits'(col_q) < cur_w_q)
    else $error("input column outside the latched frame width");

  a_ccol_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WBits'(ccol_q) < cur_w_q)
    else $error("centre column outside the latched frame width");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= cur_h_q)
    else $error("input row ran past the latched frame height");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_done |=> (row_q == '0 && col_q == '0 && crow_q == '0 && ccol_q == '0))
    else $error("counters not cleared after the last result of a frame");

endmodule

### tb/gradient_non_maximum_suppression_test.sv
// ----------------------------------------------------------------------------
// gradient_non_maximum_suppression_test: self-checking bench for the NMS block
// Streams gradient frames of many sizes through the block. Both handshakes
// idle and stall at random. A built-in predictor computes every kept
// magnitude and frame end marker, and each result is checked as it arrives.
// ----------------------------------------------------------------------------
module gradient_non_maximum_suppression_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_WIDTH     = 1024;
  localparam int unsigned MAG_BITS      = 16;
  localparam int unsigned HISTORY_DEPTH = 2 * MAX_WIDTH + 4;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned RANDOM_ITEMS  = 1050;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef struct packed {
    gnms_pkg::cmd_e cmd;
    logic [15:0]    mag;
    logic [15:0]    ang;
  } pixel_item_t;

  typedef struct packed {
    logic [15:0] kept;
    logic        last;
  } nms_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic                          cfg_index_i = 1'b0;
  logic [gnms_pkg::FH_BITS-1:0]  cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic                          command_i = 1'b0;
  logic [MAG_BITS-1:0]           magnitude_i = '0;
  logic signed [15:0]            angle_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [MAG_BITS-1:0]           kept_magnitude_o;
  logic                          frame_end_o;

  gradient_non_maximum_suppression #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAG_BITS (MAG_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .magnitude_i     (magnitude_i),
    .angle_i         (angle_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kept_magnitude_o(kept_magnitude_o),
    .frame_end_o     (frame_end_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pending stimulus and expected results.
  pixel_item_t pending_items[$];
  nms_result_t kept_expected[$];

  // Predictor state.
  logic [15:0]        mag_history[HISTORY_DEPTH];
  logic signed [15:0] ang_history[HISTORY_DEPTH];
  int unsigned        cfg_width = gnms_pkg::RST_WIDTH;
  int unsigned        cfg_height = gnms_pkg::RST_HEIGHT;
  int unsigned        frame_w = gnms_pkg::RST_WIDTH;
  int unsigned        frame_h = gnms_pkg::RST_HEIGHT;
  int unsigned        col_pos = 0;
  int unsigned        row_pos = 0;
  int unsigned        centers_done = 0;

  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned frames_closed = 0;
  int unsigned pixels_sent = 0;
  int unsigned flushes_sent = 0;
  int unsigned idle_cycles = 0;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic gnms_pkg::dir_e angle_direction(logic signed [15:0] a);
    int             v;
    gnms_pkg::dir_e d;
    v = (a < 0) ? -int'(a) : int'(a);
    if (v <= int'(gnms_pkg::TH1) || v > int'(gnms_pkg::TH7)) begin
      d = gnms_pkg::DIR_VERT;
    end else if (v <= int'(gnms_pkg::TH3)) begin
      d = (a < 0) ? gnms_pkg::DIR_TRBL : gnms_pkg::DIR_TLBR;
    end else if (v <= int'(gnms_pkg::TH5)) begin
      d = gnms_pkg::DIR_HORZ;
    end else begin
      d = (a < 0) ? gnms_pkg::DIR_TLBR : gnms_pkg::DIR_TRBL;
    end
    return d;
  endfunction

  // True when the neighbor at (row + dr, col + dc) lies in the frame and is
  // strictly larger than the center.
  function automatic bit neighbor_beats(int unsigned c, int unsigned row, int unsigned col,
                                        int dr, int dc, logic [15:0] m);
    int unsigned q;
    if (dr < 0 && row == 0) return 1'b0;
    if (dr > 0 && row + 1 >= frame_h) return 1'b0;
    if (dc < 0 && col == 0) return 1'b0;
    if (dc > 0 && col + 1 >= frame_w) return 1'b0;
    q = c;
    if (dr < 0) q = q - frame_w;
    if (dr > 0) q = q + frame_w;
    if (dc < 0) q = q - 1;
    if (dc > 0) q = q + 1;
    return m < mag_history[q % HISTORY_DEPTH];
  endfunction

  function automatic void suppress_center(int unsigned c);
    int unsigned    row, col;
    logic [15:0]    m;
    gnms_pkg::dir_e d;
    int             dc;
    bit             drop;
    nms_result_t    r;
    row = c / frame_w;
    col = c % frame_w;
    m   = mag_history[c % HISTORY_DEPTH];
    d   = angle_direction(ang_history[c % HISTORY_DEPTH]);
    dc  = (d == gnms_pkg::DIR_TLBR) ? -1 : (d == gnms_pkg::DIR_TRBL) ? 1 : 0;
    if (d == gnms_pkg::DIR_HORZ) begin
      drop = neighbor_beats(c, row, col, 0, -1, m) || neighbor_beats(c, row, col, 0, 1, m);
    end else begin
      drop = neighbor_beats(c, row, col, -1, dc, m) || neighbor_beats(c, row, col, 1, -dc, m);
    end
    r.kept = drop ? 16'd0 : m;
    r.last = (c + 1 == frame_w * frame_h);
    kept_expected.push_back(r);
  endfunction

  function automatic void predict_transaction(gnms_pkg::cmd_e cmd, logic [15:0] mag,
                                              logic signed [15:0] ang);
    int unsigned p;
    if (cmd == gnms_pkg::CMD_PIXEL) begin
      if (row_pos == 0 && col_pos == 0 && centers_done == 0) begin
        frame_w = clamp_size(cfg_width, gnms_pkg::MIN_SIZE, MAX_WIDTH);
        frame_h = clamp_size(cfg_height, gnms_pkg::MIN_SIZE, gnms_pkg::MAX_HEIGHT);
      end
      if (row_pos >= frame_h) return;  // pixels during the drain are dropped
      p = row_pos * frame_w + col_pos;
      mag_history[p % HISTORY_DEPTH] = mag;
      ang_history[p % HISTORY_DEPTH] = ang;
      col_pos++;
      if (col_pos >= frame_w) begin
        col_pos = 0;
        row_pos++;
      end
      if (p < frame_w + 1) return;
      suppress_center(p - frame_w - 1);
      centers_done++;
    end else begin
      if (row_pos < frame_h || centers_done >= frame_w * frame_h) return;
      suppress_center(centers_done);
      centers_done++;
      if (centers_done >= frame_w * frame_h) begin
        row_pos = 0;
        col_pos = 0;
        centers_done = 0;
      end
    end
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_transaction(gnms_pkg::cmd_e'(command_i), magnitude_i, angle_i);
        if (gnms_pkg::cmd_e'(command_i) == gnms_pkg::CMD_PIXEL) pixels_sent++;
        else flushes_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() != 0) begin
          nxt = pending_items.pop_front();
          in_valid_i  <= 1'b1;
          command_i   <= nxt.cmd;
          magnitude_i <= nxt.mag;
          angle_i     <= nxt.ang;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 300)
                                                     : $urandom_range(0, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: segments of no stall, random stall, or solid stall.
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = (stall_mode == 2) ? $urandom_range(1, 12) : $urandom_range(4, 60);
      end
      stall_left--;
      case (stall_mode)
        0: begin
          out_stall_i <= 1'b0;
        end
        1: begin
          out_stall_i <= ($urandom_range(0, 2) == 0);
        end
        default: begin
          out_stall_i <= 1'b1;
        end
      endcase
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    nms_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (kept_expected.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT) begin
          $display("unexpected result: kept %0d frame_end %0b", kept_magnitude_o, frame_end_o);
        end
        mismatch_count++;
      end else begin
        want = kept_expected.pop_front();
        if (want.kept !== kept_magnitude_o || want.last !== frame_end_o) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("mismatch at result %0d: expected kept %0d frame_end %0b, got %0d %0b",
                     results_checked, want.kept, want.last, kept_magnitude_o, frame_end_o);
          end
          mismatch_count++;
        end
      end
      results_checked++;
      if (frame_end_o) frames_closed++;
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, kept_expected.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_register(gnms_pkg::reg_idx_e idx, logic [gnms_pkg::FH_BITS-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == gnms_pkg::REG_FRAME_WIDTH) cfg_width = value[gnms_pkg::FW_BITS-1:0];
    else cfg_height = value;
    @(negedge clk_i);
  endtask

  // Returns once all stimulus is taken and every result is back, then lets
  // anything still in flight settle.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || kept_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic void push_item(gnms_pkg::cmd_e c, int m, int a);
    pixel_item_t it;
    it.cmd = c;
    it.mag = m[15:0];
    it.ang = a[15:0];
    pending_items.push_back(it);
  endfunction

  function automatic int pick_magnitude(int style);
    case (style)
      0: return $urandom_range(0, 3);
      1: return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1) : $urandom_range(65534, 65535);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int pick_angle();
    int b;
    case ($urandom_range(0, 9))
      0: begin
        return $urandom_range(0, 65535);  // anything the field allows
      end
      1: begin
        case ($urandom_range(0, 4))
          0: b = int'(gnms_pkg::TH1);
          1: b = int'(gnms_pkg::TH3);
          2: b = int'(gnms_pkg::TH5);
          3: b = int'(gnms_pkg::TH7);
          default: b = 25735;
        endcase
        b = b + $urandom_range(0, 1);
        return ($urandom_range(0, 1) == 0) ? b : -b;
      end
      default: begin
        return int'($urandom_range(0, 51472)) - 25736;
      end
    endcase
  endfunction

  function automatic void push_pixels(int unsigned count, bit noisy);
    int style;
    for (int unsigned i = 0; i < count; i++) begin
      // A flush before the last pixel of a frame must be ignored.
      if (noisy && $urandom_range(0, 15) == 0) begin
        push_item(gnms_pkg::CMD_FLUSH, pick_magnitude(2), pick_angle());
      end
      style = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(0, 2) == 0 ? 0 : 2;
      push_item(gnms_pkg::CMD_PIXEL, pick_magnitude(style), pick_angle());
    end
  endfunction

  function automatic void push_drain(int unsigned w, bit noisy);
    for (int unsigned j = 0; j <= w; j++) begin
      // A pixel while the frame drains must be ignored.
      if (noisy && $urandom_range(0, 7) == 0) begin
        push_item(gnms_pkg::CMD_PIXEL, pick_magnitude(2), pick_angle());
      end
      push_item(gnms_pkg::CMD_FLUSH, pick_magnitude(2), pick_angle());
    end
    if (noisy && $urandom_range(0, 3) == 0) push_item(gnms_pkg::CMD_FLUSH, 0, 0);
  endfunction

  initial begin
    int unsigned w, h, w_raw, h_raw, frames;
    int unsigned random_items;
    random_items = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: 2x2 frame from out-of-range sizes, with ignored flushes and
    // a pixel during the drain.
    write_register(gnms_pkg::REG_FRAME_WIDTH, 13'd0);
    write_register(gnms_pkg::REG_FRAME_HEIGHT, 13'd1);
    push_item(gnms_pkg::CMD_FLUSH, 65535, -32768);
    push_item(gnms_pkg::CMD_PIXEL, 65535, 25736);
    push_item(gnms_pkg::CMD_PIXEL, 0, -25736);
    push_item(gnms_pkg::CMD_PIXEL, 1, 0);
    push_item(gnms_pkg::CMD_FLUSH, 0, 0);
    push_item(gnms_pkg::CMD_PIXEL, 65534, -32768);
    push_item(gnms_pkg::CMD_FLUSH, 0, 0);
    push_item(gnms_pkg::CMD_PIXEL, 16'h1234, 32767);
    push_item(gnms_pkg::CMD_FLUSH, 0, 0);
    push_item(gnms_pkg::CMD_FLUSH, 0, 0);
    push_item(gnms_pkg::CMD_FLUSH, 0, 0);
    wait_idle();

    // Directed: 3x3 frame with angles on both sides of TH1 and TH7, just above TH3 and TH5.
    write_register(gnms_pkg::REG_FRAME_WIDTH, 13'd3);
    write_register(gnms_pkg::REG_FRAME_HEIGHT, 13'd3);
    push_item(gnms_pkg::CMD_PIXEL, 7, 3217);
    push_item(gnms_pkg::CMD_PIXEL, 2, -3217);
    push_item(gnms_pkg::CMD_PIXEL, 9, 9651);
    push_item(gnms_pkg::CMD_PIXEL, 4, 22518);
    push_item(gnms_pkg::CMD_PIXEL, 5, 16085);
    push_item(gnms_pkg::CMD_PIXEL, 5, -16085);
    push_item(gnms_pkg::CMD_PIXEL, 1, 22519);
    push_item(gnms_pkg::CMD_PIXEL, 8, 3216);
    push_item(gnms_pkg::CMD_PIXEL, 3, -9651);
    push_drain(3, 1'b0);
    wait_idle();

    // Size written mid-frame: the running 5x4 frame keeps its size and the
    // next frame picks up 7x3.
    write_register(gnms_pkg::REG_FRAME_WIDTH, 13'd5);
    write_register(gnms_pkg::REG_FRAME_HEIGHT, 13'd4);
    push_pixels(9, 1'b0);
    wait_idle();
    write_register(gnms_pkg::REG_FRAME_WIDTH, 13'd7);
    write_register(gnms_pkg::REG_FRAME_HEIGHT, 13'd3);
    push_pixels(11, 1'b1);
    push_drain(5, 1'b1);
    push_pixels(21, 1'b0);
    push_drain(7, 1'b0);
    random_items += 20 + 6 + 21 + 8;

    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: w_raw = $urandom_range(0, 1);
        1: w_raw = $urandom_range(13, 24);
        default: w_raw = $urandom_range(2, 10);
      endcase
      case ($urandom_range(0, 9))
        0: h_raw = $urandom_range(0, 1);
        1: h_raw = $urandom_range(9, 16);
        default: h_raw = $urandom_range(2, 8);
      endcase
      write_register(gnms_pkg::REG_FRAME_WIDTH, w_raw[gnms_pkg::FH_BITS-1:0]);
      write_register(gnms_pkg::REG_FRAME_HEIGHT, h_raw[gnms_pkg::FH_BITS-1:0]);
      w = clamp_size(cfg_width, gnms_pkg::MIN_SIZE, MAX_WIDTH);
      h = clamp_size(cfg_height, gnms_pkg::MIN_SIZE, gnms_pkg::MAX_HEIGHT);
      frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames && random_items < RANDOM_ITEMS; f++) begin
        push_pixels(w * h, $urandom_range(0, 2) == 0);
        push_drain(w, $urandom_range(0, 2) == 0);
        random_items += w * h + w + 1;
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("checked %0d results in %0d frames from %0d pixel and %0d flush transactions",
             results_checked, frames_closed, pixels_sent, flushes_sent);
    $display("frames ranged from 2x2 to 24x16, with clamped and mid-frame size writes");
    if (mismatch_count == 0 && kept_expected.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/gnms_pkg.sv
hdl/gnms_ram.sv
hdl/gradient_non_maximum_suppression.sv
tb/gradient_non_maximum_suppression_test.sv
